// ===== design/edz_pkg.sv =====
package edz_pkg;

    // floor(p / 125000) = (p[31:3] * DIV_RECIP) >> DIV_SHIFT, exact for any 32-bit p
    localparam logic [29:0] DIV_RECIP = 30'd562949954;
    localparam int unsigned DIV_SHIFT = 43;

    localparam logic [15:0] SPEED_RESET = 16'd34350;
    localparam logic [13:0] D16_MAX = 14'h3FFF;
    localparam logic [7:0] DUTY_MAX = 8'd250;
    localparam logic [13:0] NEAR_16 = 14'd800;
    localparam logic [13:0] EDGE1_16 = 14'd2400;
    localparam logic [13:0] EDGE2_16 = 14'd4000;
    localparam logic [13:0] EDGE3_16 = 14'd5600;

    localparam logic [2:0] SECTION_NONE = 3'd0;
    localparam logic [2:0] ZONE_NEAR = 3'd1;
    localparam logic [2:0] ZONE_MID = 3'd2;
    localparam logic [2:0] ZONE_OUTER = 3'd3;
    localparam logic [2:0] ZONE_FAR = 3'd4;

    typedef struct packed {
        logic        side;
        logic        new_burst;
        logic [15:0] echo_time_us;
    } edz_in_t;

    typedef struct packed {
        logic [2:0]  section;
        logic        drive_valid;
        logic [2:0]  drive_channel;
        logic [7:0]  drive_duty;
        logic [7:0]  release_mask;
        logic [13:0] distance_sixteenths;
    } edz_out_t;

    typedef struct packed {
        logic        side;
        logic        new_burst;
        logic        no_echo;
        logic [13:0] d16;
    } edz_qitem_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_DIV,
        FR_DONE
    } edz_front_state_t;

    function automatic logic [2:0] zone_of(input logic [13:0] d16);
        logic [2:0] z;
        if (d16 < EDGE1_16)
            z = ZONE_NEAR;
        else if (d16 < EDGE2_16)
            z = ZONE_MID;
        else if (d16 < EDGE3_16)
            z = ZONE_OUTER;
        else
            z = ZONE_FAR;
        return z;
    endfunction

    function automatic logic [2:0] channel_of(input logic side, input logic [2:0] zone);
        logic [2:0] c;
        if (side)
            c = 3'd3 + zone;
        else
            c = 3'd4 - zone;
        return c;
    endfunction

endpackage

// ===== design/edz_front.sv =====
module edz_front #(
    parameter int unsigned MAX_ECHO_US = 45000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  edz_pkg::edz_in_t    in_data,
    input  logic [15:0]         speed,
    output logic                q_valid,
    input  logic                q_ready,
    output edz_pkg::edz_qitem_t q_data
);
    import edz_pkg::*;

    edz_front_state_t state_reg, state_next;
    logic        side_reg, side_next;
    logic        burst_reg, burst_next;
    logic [15:0] time_reg, time_next;
    logic [31:0] prod_reg, prod_next;
    logic [15:0] quo_reg, quo_next;

    logic [31:0] product;
    logic [58:0] recip_prod;

    assign product = {16'b0, speed} * {16'b0, time_reg};
    // 125000 = 8 * 15625: drop three bits, then multiply by the reciprocal of 15625
    assign recip_prod = {30'b0, prod_reg[31:3]} * {29'b0, DIV_RECIP};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (in_valid)
                    state_next = FR_MUL;
            end
            FR_MUL:
                state_next = FR_DIV;
            FR_DIV:
                state_next = FR_DONE;
            FR_DONE:
            begin
                if (q_ready)
                    state_next = FR_IDLE;
            end
            default:
                state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        q_valid = 1'b0;
        case (state_reg)
            FR_IDLE: in_ready = 1'b1;
            FR_DONE: q_valid = 1'b1;
            default:
            begin
                in_ready = 1'b0;
                q_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        side_next = side_reg;
        burst_next = burst_reg;
        time_next = time_reg;
        prod_next = prod_reg;
        quo_next = quo_reg;
        case (state_reg)
            FR_IDLE:
            begin
                side_next = in_data.side;
                burst_next = in_data.new_burst;
                time_next = in_data.echo_time_us;
            end
            FR_MUL:
                prod_next = product;
            FR_DIV:
                quo_next = recip_prod[DIV_SHIFT +: 16];
            default:
                quo_next = quo_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        burst_reg <= burst_next;
        time_reg <= time_next;
        prod_reg <= prod_next;
        quo_reg <= quo_next;
    end

    assign q_data.side = side_reg;
    assign q_data.new_burst = burst_reg;
    assign q_data.no_echo = ({1'b0, time_reg} >= 17'(MAX_ECHO_US));
    assign q_data.d16 = (|quo_reg[15:14]) ? D16_MAX : quo_reg[13:0];

endmodule

// ===== design/edz_queue.sv =====
module edz_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  edz_pkg::edz_qitem_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output edz_pkg::edz_qitem_t rd_data
);
    import edz_pkg::*;

    edz_qitem_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== design/edz_back.sv =====
module edz_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  edz_pkg::edz_qitem_t q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output edz_pkg::edz_out_t   out_data
);
    import edz_pkg::*;

    logic [2:0] section_reg, section_next;
    logic       out_valid_reg, out_valid_next;
    edz_out_t   out_data_reg, out_data_next;

    logic        pop;
    logic [2:0]  sec0;
    logic [2:0]  zone;
    logic        act;
    logic [13:0] start16;
    logic [13:0] diff;
    logic [16:0] scaled;
    logic [11:0] duty_raw;
    logic [7:0]  duty;
    logic [7:0]  rel;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop = q_valid && q_ready;

    assign sec0 = q_data.new_burst ? SECTION_NONE : section_reg;
    assign zone = zone_of(q_data.d16);
    assign act = !q_data.no_echo && (sec0 < ZONE_FAR) && (zone > sec0);

    always_comb
    begin
        case (zone)
            ZONE_NEAR:  start16 = NEAR_16;
            ZONE_MID:   start16 = EDGE1_16;
            ZONE_OUTER: start16 = EDGE2_16;
            default:    start16 = EDGE3_16;
        endcase
    end

    assign diff = (q_data.d16 < start16) ? 14'd0 : q_data.d16 - start16;
    assign scaled = {1'b0, diff, 2'b00} + {3'b000, diff};
    assign duty_raw = scaled[16:5];
    assign duty = (duty_raw > {4'b0, DUTY_MAX}) ? DUTY_MAX : duty_raw[7:0];

    always_comb
    begin
        rel = '0;
        for (int k = 1; k < 4; k++)
        begin
            if (act && (3'(k) > sec0) && (3'(k) < zone))
                rel[channel_of(q_data.side, 3'(k))] = 1'b1;
        end
    end

    always_comb
    begin
        section_next = section_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            section_next = act ? zone : sec0;
            out_valid_next = 1'b1;
            out_data_next.section = section_next;
            out_data_next.drive_valid = act;
            out_data_next.drive_channel = act ? channel_of(q_data.side, zone) : 3'd0;
            out_data_next.drive_duty = act ? duty : 8'd0;
            out_data_next.release_mask = rel;
            out_data_next.distance_sixteenths = q_data.d16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= SECTION_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            section_reg <= section_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== design/echo_distance_zone_haptic_driver.sv =====
// The front part takes one echo at a time through its states: capture, multiply,
// reciprocal multiply for distance = speed * time / 125000, hand-off to queue;
// it accepts the next echo only after the queue has taken the last one.
// Reset (rst_n, async, active low): section 0, sound speed 34350 cm/s,
// queue and output register empty.
module echo_distance_zone_haptic_driver #(
    parameter int unsigned MAX_ECHO_US = 45000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  edz_pkg::edz_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output edz_pkg::edz_out_t out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);
    import edz_pkg::*;

    logic [15:0] speed_reg, speed_next;
    logic        fq_valid, fq_ready;
    edz_qitem_t  fq_data;
    logic        qb_valid, qb_ready;
    edz_qitem_t  qb_data;

    assign speed_next = cfg_we ? cfg_wdata : speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else
            speed_reg <= speed_next;
    end

    edz_front #(
        .MAX_ECHO_US(MAX_ECHO_US)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .speed    (speed_reg),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    edz_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    edz_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_section_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.section <= ZONE_FAR)
        else $error("section out of range");

    a_idle_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.drive_valid) |->
            (out_data.drive_channel == 3'd0 && out_data.drive_duty == 8'd0 &&
             out_data.release_mask == 8'd0))
        else $error("payload set without drive");

    a_drive_not_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.drive_valid) |->
            (!out_data.release_mask[out_data.drive_channel] &&
             out_data.drive_duty <= DUTY_MAX && out_data.section != SECTION_NONE))
        else $error("driven channel inconsistent");

endmodule

// ===== tb/sv/tb_echo_distance_zone_haptic_driver.sv =====
`timescale 1ns / 1ps

module tb_echo_distance_zone_haptic_driver;
    import edz_pkg::*;

    localparam int MAX_ECHO_US = 45000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT = 2000;

    class echo_scoreboard;
        logic [15:0] speed_cm_s;
        logic [2:0] burst_section;
        edz_out_t drive_q[$];
        int errors;

        function new();
            speed_cm_s = SPEED_RESET;
            burst_section = SECTION_NONE;
            errors = 0;
        endfunction

        function logic [2:0] zone_for(logic [13:0] d16);
            if (d16 < EDGE1_16)
                return ZONE_NEAR;
            if (d16 < EDGE2_16)
                return ZONE_MID;
            if (d16 < EDGE3_16)
                return ZONE_OUTER;
            return ZONE_FAR;
        endfunction

        function logic [2:0] haptic_channel(logic side, int zone);
            int c;
            c = side ? 3 + zone : 4 - zone;
            return c[2:0];
        endfunction

        function logic [7:0] duty_for(logic [2:0] zone, logic [13:0] d16);
            logic [13:0] start;
            int v;
            case (zone)
                ZONE_NEAR: start = NEAR_16;
                ZONE_MID: start = EDGE1_16;
                ZONE_OUTER: start = EDGE2_16;
                default: start = EDGE3_16;
            endcase
            if (d16 < start)
                return 8'd0;
            v = (5 * (int'(d16) - int'(start))) >>> 5;
            if (v > int'(DUTY_MAX))
                v = int'(DUTY_MAX);
            return v[7:0];
        endfunction

        function edz_out_t predict_drive(edz_in_t e);
            logic [47:0] prod;
            logic [47:0] q;
            logic [13:0] d16;
            logic [2:0] z;
            edz_out_t r;
            prod = 48'(speed_cm_s) * 48'(e.echo_time_us);
            q = prod / 48'd125000;
            d16 = (q > 48'(D16_MAX)) ? D16_MAX : q[13:0];
            r = '0;
            r.distance_sixteenths = d16;
            if (e.new_burst)
                burst_section = SECTION_NONE;
            if (int'(e.echo_time_us) < MAX_ECHO_US && burst_section < ZONE_FAR)
            begin
                z = zone_for(d16);
                if (z > burst_section)
                begin
                    for (int k = int'(burst_section) + 1; k < int'(z); k++)
                        r.release_mask[haptic_channel(e.side, k)] = 1'b1;
                    r.drive_valid = 1'b1;
                    r.drive_channel = haptic_channel(e.side, int'(z));
                    r.drive_duty = duty_for(z, d16);
                    burst_section = z;
                end
            end
            r.section = burst_section;
            return r;
        endfunction

        function void note_echo(edz_in_t e);
            drive_q.push_back(predict_drive(e));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_drive(edz_out_t got);
            edz_out_t want;
            if (drive_q.size() == 0)
            begin
                $error("unexpected result transfer: %h", got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            compare_field("section", 16'(want.section), 16'(got.section));
            compare_field("drive_valid", 16'(want.drive_valid), 16'(got.drive_valid));
            compare_field("drive_channel", 16'(want.drive_channel), 16'(got.drive_channel));
            compare_field("drive_duty", 16'(want.drive_duty), 16'(got.drive_duty));
            compare_field("release_mask", 16'(want.release_mask), 16'(got.release_mask));
            compare_field("distance_sixteenths", 16'(want.distance_sixteenths),
                          16'(got.distance_sixteenths));
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    edz_in_t in_data;
    logic out_valid;
    logic out_ready;
    edz_out_t out_data;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    echo_scoreboard sb;
    bit idle_on;
    bit hold_req;
    int quiet_cycles;

    echo_distance_zone_haptic_driver #(
        .MAX_ECHO_US(MAX_ECHO_US)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic edz_in_t make_echo(logic side, logic burst, logic [15:0] t);
        edz_in_t e;
        e.side = side;
        e.new_burst = burst;
        e.echo_time_us = t;
        return e;
    endfunction

    task automatic send_echo(edz_in_t e);
        int gap;
        @(negedge clk);
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = e;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_echo(e);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_speed(logic [15:0] speed);
        wait_drained();
        cfg_we = 1'b1;
        cfg_wdata = speed;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.speed_cm_s = speed;
    endtask

    task automatic run_bursts(int n);
        int sent;
        int len;
        int t;
        logic side;
        logic burst;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 6);
            side = 1'($urandom_range(0, 1));
            t = $urandom_range(0, 8000);
            for (int i = 0; i < len && sent < n; i++)
            begin
                if (i == 0)
                    burst = ($urandom_range(0, 19) != 0);
                else
                    burst = ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 9) == 0)
                    side = ~side;
                send_echo(make_echo(side, burst, 16'(t)));
                sent++;
                if ($urandom_range(0, 11) == 0)
                    t = $urandom_range(0, 65535);
                else if ($urandom_range(0, 11) == 0)
                    t = $urandom_range(0, 44999);
                else
                begin
                    t = (t > 44999 ? 0 : t) + $urandom_range(0, 9000);
                    if (t > 44999)
                        t = 44999;
                end
            end
        end
    endtask

    task automatic receive_drives();
        int stall;
        forever
        begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_drive(out_data);
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        receive_drives();
    end

    initial
    begin
        sb = new();
        quiet_cycles = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset speed
        run_bursts(30);

        // 31250 cm/s gives d16 = t / 4, so zone edges land on exact times
        write_speed(16'd31250);
        send_echo(make_echo(1'b0, 1'b1, 16'd0));
        send_echo(make_echo(1'b0, 1'b0, 16'd3199));
        send_echo(make_echo(1'b1, 1'b1, 16'd3232));
        send_echo(make_echo(1'b1, 1'b0, 16'd9599));
        send_echo(make_echo(1'b1, 1'b0, 16'd9600));
        send_echo(make_echo(1'b1, 1'b0, 16'd22399));
        send_echo(make_echo(1'b1, 1'b0, 16'd22400));
        send_echo(make_echo(1'b1, 1'b0, 16'd0));
        send_echo(make_echo(1'b0, 1'b1, 16'd22400));
        send_echo(make_echo(1'b1, 1'b1, 16'd30000));
        send_echo(make_echo(1'b0, 1'b1, 16'd45000));
        send_echo(make_echo(1'b0, 1'b0, 16'd44999));
        send_echo(make_echo(1'b0, 1'b1, 16'd65535));
        send_echo(make_echo(1'b1, 1'b1, 16'd16000));
        send_echo(make_echo(1'b1, 1'b0, 16'd15999));
        send_echo(make_echo(1'b1, 1'b1, 16'd9600));
        send_echo(make_echo(1'b1, 1'b0, 16'd65535));
        send_echo(make_echo(1'b1, 1'b0, 16'd16000));
        send_echo(make_echo(1'b0, 1'b1, 16'd9599));
        send_echo(make_echo(1'b0, 1'b0, 16'd45001));
        send_echo(make_echo(1'b0, 1'b1, 16'd12800));

        // long output stall while input keeps coming
        write_speed(16'd30000);
        hold_req = 1'b1;
        run_bursts(100);

        write_speed(16'd36000);
        idle_on = 1'b0;
        run_bursts(80);

        write_speed(16'($urandom_range(30000, 36000)));
        idle_on = 1'b1;
        run_bursts(100);

        write_speed(SPEED_RESET);
        run_bursts(90);

        wait_drained();
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/edz_pkg.sv
design/edz_front.sv
design/edz_queue.sv
design/edz_back.sv
design/echo_distance_zone_haptic_driver.sv
tb/sv/tb_echo_distance_zone_haptic_driver.sv
